// ----- src/sat_pkg.sv -----
// Shared constants and the controller-to-datapath command type of the summed-area table block.
package sat_pkg;

   localparam int GRID_W  = 7;
   localparam int BOUND_W = 7;
   localparam int SUM_W   = 28;

   localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] TAP_BOT_RIGHT = 2'd0;
   localparam logic [1:0] TAP_BOT_LEFT  = 2'd1;
   localparam logic [1:0] TAP_TOP_RIGHT = 2'd2;
   localparam logic [1:0] TAP_TOP_LEFT  = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       csr_write;
      logic       load_read;
      logic       load_write;
      logic       tap_read;
      logic [1:0] tap_sel;
      logic       tap_acc;
      logic       finish;
   } sat_cmd_type;

endpackage

// ----- src/sat_ctrl.sv -----
// Sequencer for table loads and four-entry rectangle queries.
module sat_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_func,
   input  logic                 csr_valid,
   output logic                 busy,
   output logic                 csr_ready,
   output sat_pkg::sat_cmd_type cmd
);
   import sat_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_READ,
      ST_LOAD_WRITE,
      ST_TAP0,
      ST_TAP1,
      ST_TAP2,
      ST_TAP3,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;
   logic      accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               busy_in  = 1'b1;
               state_in = (req_func == FUNC_QUERY) ? ST_TAP0 : ST_LOAD_READ;
            end
         end
         ST_LOAD_READ:  state_in = ST_LOAD_WRITE;
         ST_LOAD_WRITE: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         ST_TAP0:   state_in = ST_TAP1;
         ST_TAP1:   state_in = ST_TAP2;
         ST_TAP2:   state_in = ST_TAP3;
         ST_TAP3:   state_in = ST_FINISH;
         ST_FINISH: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.csr_write = csr_valid && !busy_ff;
      case (state_ff)
         ST_LOAD_READ:  cmd.load_read = 1'b1;
         ST_LOAD_WRITE: cmd.load_write = 1'b1;
         ST_TAP0: begin
            cmd.tap_read = 1'b1;
            cmd.tap_sel  = TAP_BOT_RIGHT;
         end
         ST_TAP1: begin
            cmd.tap_read = 1'b1;
            cmd.tap_sel  = TAP_BOT_LEFT;
            cmd.tap_acc  = 1'b1;
         end
         ST_TAP2: begin
            cmd.tap_read = 1'b1;
            cmd.tap_sel  = TAP_TOP_RIGHT;
            cmd.tap_acc  = 1'b1;
         end
         ST_TAP3: begin
            cmd.tap_read = 1'b1;
            cmd.tap_sel  = TAP_TOP_LEFT;
            cmd.tap_acc  = 1'b1;
         end
         ST_FINISH: cmd.finish = 1'b1;
         default: cmd.finish = 1'b0;
      endcase
   end

   // The idle flag and the state must agree, or requests get lost or doubled.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy flag out of step with the state");

   // A load request always takes the read-then-write path.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_LOAD) |=> ##1 (state_ff == ST_LOAD_WRITE))
      else $error("load did not reach its write step");

endmodule

// ----- src/sat_datapath.sv -----
// Table memory, load position, running row sum and query accumulator.
module sat_datapath #(
   parameter int MAX_SIDE  = 64,
   parameter int ELEM_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sat_pkg::sat_cmd_type              cmd,
   input  logic        [ELEM_BITS-1:0]       req_elem_value,
   input  logic        [sat_pkg::BOUND_W-1:0] req_row_top,
   input  logic        [sat_pkg::BOUND_W-1:0] req_row_bottom,
   input  logic        [sat_pkg::BOUND_W-1:0] req_col_left,
   input  logic        [sat_pkg::BOUND_W-1:0] req_col_right,
   input  logic        [sat_pkg::GRID_W-1:0]  csr_grid_size,
   output logic                              rsp_valid,
   output logic signed [sat_pkg::SUM_W-1:0]   rsp_rect_sum,
   output logic                              rsp_query_error
);
   import sat_pkg::*;

   localparam int CW    = ($clog2(MAX_SIDE) > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 2 ** AW;
   localparam int NW    = ($clog2(MAX_SIDE + 1) > GRID_W) ? $clog2(MAX_SIDE + 1) : GRID_W;

   logic [SUM_W-1:0]     table_mem [DEPTH];

   logic [GRID_W-1:0]    grid_ff;
   logic [CW-1:0]        load_row_ff;
   logic [CW-1:0]        load_col_ff;
   logic [SUM_W-1:0]     run_sum_ff;
   logic                 ready_ff;
   logic [ELEM_BITS-1:0] elem_ff;
   logic [BOUND_W-1:0]   top_ff;
   logic [BOUND_W-1:0]   bot_ff;
   logic [BOUND_W-1:0]   left_ff;
   logic [BOUND_W-1:0]   right_ff;
   logic [SUM_W-1:0]     rd_data_ff;
   logic                 tap_zero_ff;
   logic                 tap_neg_ff;
   logic [SUM_W-1:0]     acc_ff;
   logic                 rsp_valid_ff;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic                 rsp_err_ff;

   logic [NW-1:0]        side;
   logic [BOUND_W-1:0]   tap_row;
   logic [BOUND_W-1:0]   tap_col;
   logic                 tap_zero;
   logic [AW-1:0]        tap_addr;
   logic [AW-1:0]        mem_addr;
   logic                 mem_re;
   logic [SUM_W-1:0]     elem_ext;
   logic [SUM_W-1:0]     row_sum;
   logic [SUM_W-1:0]     above;
   logic [SUM_W-1:0]     wdata;
   logic                 col_last;
   logic                 row_last;
   logic [SUM_W-1:0]     contrib;
   logic                 bad;

   always_comb begin
      if (grid_ff == '0) begin
         side = NW'(1);
      end else if (NW'(grid_ff) > NW'(MAX_SIDE)) begin
         side = NW'(MAX_SIDE);
      end else begin
         side = NW'(grid_ff);
      end
   end

   // Tap order: bottom-right and top-left add, the two mixed corners subtract.
   assign tap_row  = cmd.tap_sel[1] ? (top_ff - BOUND_W'(1)) : bot_ff;
   assign tap_col  = cmd.tap_sel[0] ? (left_ff - BOUND_W'(1)) : right_ff;
   assign tap_zero = (tap_row == '0) || (tap_col == '0);
   assign tap_addr = {CW'(tap_row - BOUND_W'(1)), CW'(tap_col - BOUND_W'(1))};

   always_comb begin
      if (cmd.tap_read) begin
         mem_addr = tap_addr;
      end else if (cmd.load_read) begin
         mem_addr = {load_row_ff - CW'(1), load_col_ff};
      end else begin
         mem_addr = {load_row_ff, load_col_ff};
      end
   end

   assign mem_re = cmd.tap_read || cmd.load_read;

   // All table arithmetic is modulo the result width, which keeps the
   // inclusion-exclusion sum exact after the final wrap.
   assign elem_ext = SUM_W'($signed(elem_ff));
   assign row_sum  = ((load_col_ff == '0) ? '0 : run_sum_ff) + elem_ext;
   assign above    = (load_row_ff == '0) ? '0 : rd_data_ff;
   assign wdata    = row_sum + above;
   assign col_last = (NW'(load_col_ff) + NW'(1)) == side;
   assign row_last = (NW'(load_row_ff) + NW'(1)) == side;

   assign contrib = tap_zero_ff ? '0 : (tap_neg_ff ? ('0 - rd_data_ff) : rd_data_ff);

   assign bad = !ready_ff || (top_ff == '0) || (left_ff == '0)
             || (NW'(bot_ff) > side) || (NW'(right_ff) > side)
             || (top_ff > bot_ff) || (left_ff > right_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         table_mem[mem_addr] <= wdata;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff      <= GRID_RESET;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         run_sum_ff   <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.csr_write) begin
            grid_ff     <= csr_grid_size;
            load_row_ff <= '0;
            load_col_ff <= '0;
            run_sum_ff  <= '0;
            ready_ff    <= 1'b0;
         end else if (cmd.load_write) begin
            run_sum_ff <= row_sum;
            if (col_last) begin
               load_col_ff <= '0;
               if (row_last) begin
                  load_row_ff <= '0;
               end else begin
                  load_row_ff <= load_row_ff + CW'(1);
               end
            end else begin
               load_col_ff <= load_col_ff + CW'(1);
            end
            // The first load of a pass drops the flag; the last one raises it.
            if (col_last && row_last) begin
               ready_ff <= 1'b1;
            end else if (load_row_ff == '0 && load_col_ff == '0) begin
               ready_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elem_ff  <= req_elem_value;
         top_ff   <= req_row_top;
         bot_ff   <= req_row_bottom;
         left_ff  <= req_col_left;
         right_ff <= req_col_right;
         acc_ff   <= '0;
      end else if (cmd.tap_acc) begin
         acc_ff <= acc_ff + contrib;
      end
      if (cmd.tap_read) begin
         tap_zero_ff <= tap_zero;
         tap_neg_ff  <= cmd.tap_sel[1] ^ cmd.tap_sel[0];
      end
      if (cmd.finish) begin
         rsp_sum_ff <= bad ? '0 : (acc_ff + contrib);
         rsp_err_ff <= bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_sum    = $signed(rsp_sum_ff);
   assign rsp_query_error = rsp_err_ff;

   // The load position never leaves the grid in use.
   assert property (@(posedge clock) disable iff (reset)
      (NW'(load_col_ff) < side) && (NW'(load_row_ff) < side))
      else $error("load position outside the grid");

   // A completed table stays complete until a new pass or a size write.
   assert property (@(posedge clock) disable iff (reset)
      ($past(ready_ff) && !ready_ff) |-> ($past(cmd.csr_write) || $past(cmd.load_write)))
      else $error("table ready flag dropped without a load or size write");

endmodule

// ----- src/summed_area_table_query.sv -----
// Top level of the summed-area table builder with rectangle-sum queries.
//
//   channel   ports                         handshake
//   request   req_func .. req_col_right     start high while busy low
//   response  rsp_rect_sum, rsp_query_error rsp_valid high for one cycle
//   config    csr_grid_size                 csr_valid and csr_ready high
//
// A load request takes one registered read of the entry above, then the write.
// A query request takes four registered reads through the single table
// memory port, then the final sum; the response strobes in the cycle after that.
// Reset leaves the grid size at 64 and the table not ready; table contents are undefined
// until loaded. The response side cannot stall; each response is shown for one cycle.
module summed_area_table_query #(
   parameter int MAX_SIDE  = 64,
   parameter int ELEM_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic        [ELEM_BITS-1:0]       req_elem_value,
   input  logic        [sat_pkg::BOUND_W-1:0] req_row_top,
   input  logic        [sat_pkg::BOUND_W-1:0] req_row_bottom,
   input  logic        [sat_pkg::BOUND_W-1:0] req_col_left,
   input  logic        [sat_pkg::BOUND_W-1:0] req_col_right,
   output logic                              rsp_valid,
   output logic signed [sat_pkg::SUM_W-1:0]   rsp_rect_sum,
   output logic                              rsp_query_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic        [sat_pkg::GRID_W-1:0]  csr_grid_size
);
   import sat_pkg::*;

   sat_cmd_type cmd;

   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .csr_valid (csr_valid),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   sat_datapath #(
      .MAX_SIDE  (MAX_SIDE),
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_elem_value  (req_elem_value),
      .req_row_top     (req_row_top),
      .req_row_bottom  (req_row_bottom),
      .req_col_left    (req_col_left),
      .req_col_right   (req_col_right),
      .csr_grid_size   (csr_grid_size),
      .rsp_valid       (rsp_valid),
      .rsp_rect_sum    (rsp_rect_sum),
      .rsp_query_error (rsp_query_error)
   );

   // Every query request is answered once its four tap reads and the finish step are done.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_QUERY) |-> ##6 rsp_valid)
      else $error("query response missing or late");

   // Responses never come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

endmodule
